/* design/mmpm_pkg.sv */
package mmpm_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 20;
  localparam int POS_BITS          = OFFSET_BITS + 1;
  localparam int LEN_BITS          = 5;
  localparam int CFG_DATA_BITS     = 64;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int WIN_BITS          = 8 * MAX_PATTERN_BYTES;
  localparam int SHIFT_BITS        = $clog2(MAX_PATTERN_BYTES);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_MASK_LOW       = 3'd2,
    REG_MASK_HIGH      = 3'd3,
    REG_PATTERN_LENGTH = 3'd4,
    REG_START_OFFSET   = 3'd5,
    REG_OFFSET_RANGE   = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } src_beat_t;

  typedef struct packed {
    logic                matched;
    logic [POS_BITS-1:0] match_offset;
  } res_beat_t;

endpackage

/* design/masked_magic_pattern_matcher.sv */
// Channel  | Dir | Handshake             | Beat payload
// ---------+-----+-----------------------+-------------------------------------
// src      | in  | src_valid / src_stall | src_data: data_byte, last_byte
// res      | out | res_valid / res_stall | res_data: matched, match_offset
// cfg      | in  | cfg_write             | cfg_index, cfg_data (no read-back)
//
// One file byte is taken every cycle while src_stall is low; the masked compare
// over the 16-byte window and the offset checks finish between the state registers
// and the result register, so a result appears in the cycle after the byte that causes it.
// The result register parts the two sides: src_stall is high only while a
// result is held in it and res_stall is high.
// Reset (rst, synchronous) loads the register reset values, clears the window,
// position and decided flag, and empties the result register.
module masked_magic_pattern_matcher import mmpm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      src_valid,
  output logic                      src_stall,
  input  src_beat_t                 src_data,
  output logic                      res_valid,
  input  logic                      res_stall,
  output res_beat_t                 res_data,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers
  logic [WIN_BITS-1:0]    pattern;
  logic [WIN_BITS-1:0]    mask;
  logic [LEN_BITS-1:0]    pattern_length;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] offset_range;

  // Per-file state
  logic [7:0]          byte_window [MAX_PATTERN_BYTES];
  logic [POS_BITS-1:0] byte_position;
  logic                decided;

  logic                src_fire;
  logic [WIN_BITS-1:0] win_flat;
  logic [WIN_BITS-1:0] win_aligned;
  logic [SHIFT_BITS-1:0] win_shift;
  logic [MAX_PATTERN_BYTES-1:0] lane_ok;
  logic                win_match;
  logic                len_ok;
  logic                pos_full;
  logic [POS_BITS-1:0] pos_inc;
  logic [POS_BITS-1:0] start_cand;
  logic [POS_BITS-1:0] start_ext;
  logic [POS_BITS-1:0] end_offset;
  logic                test_now;
  logic                hit;
  logic                range_done;
  logic                produce;
  logic [POS_BITS-1:0] byte_position_next;
  logic                decided_next;

  assign src_stall = res_valid && res_stall;
  assign src_fire  = src_valid && !src_stall;

  // Config writes: unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      mask           <= '1;
      pattern_length <= '0;
      start_offset   <= '0;
      offset_range   <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        REG_PATTERN_LOW:    pattern[CFG_DATA_BITS-1:0]        <= cfg_data;
        REG_PATTERN_HIGH:   pattern[WIN_BITS-1:CFG_DATA_BITS] <= cfg_data;
        REG_MASK_LOW:       mask[CFG_DATA_BITS-1:0]           <= cfg_data;
        REG_MASK_HIGH:      mask[WIN_BITS-1:CFG_DATA_BITS]    <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_BITS-1:0];
        REG_START_OFFSET:   start_offset   <= cfg_data[OFFSET_BITS-1:0];
        REG_OFFSET_RANGE:   offset_range   <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window after this byte shifts in: byte k at bits 8k+7:8k, newest on top
  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
      win_flat[8*k +: 8] = byte_window[k+1];
    end
    win_flat[WIN_BITS-1 -: 8] = src_data.data_byte;
  end

  // Right-align the newest pattern_length bytes onto pattern lane 0
  assign win_shift   = SHIFT_BITS'(LEN_BITS'(MAX_PATTERN_BYTES) - pattern_length);
  assign win_aligned = win_flat >> {win_shift, 3'b000};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      lane_ok[i] = (LEN_BITS'(i) >= pattern_length) ||
                   (((win_aligned[8*i +: 8] ^ pattern[8*i +: 8]) & mask[8*i +: 8]) == 8'd0);
    end
  end
  assign win_match = &lane_ok;

  // Start offset tested by this byte is position + 1 - length
  assign len_ok     = (pattern_length != '0) &&
                      (pattern_length <= LEN_BITS'(MAX_PATTERN_BYTES));
  assign pos_full   = (byte_position == POS_MAX);
  assign pos_inc    = byte_position + 1'b1;
  assign start_cand = pos_inc - POS_BITS'(pattern_length);
  assign start_ext  = POS_BITS'(start_offset);
  assign end_offset = POS_BITS'(start_offset) + POS_BITS'(offset_range);

  assign test_now   = !decided && !pos_full && len_ok &&
                      (pos_inc >= POS_BITS'(pattern_length));
  assign hit        = test_now && (start_cand >= start_ext) &&
                      (start_cand <= end_offset) && win_match;
  assign range_done = test_now && !hit && (start_cand >= end_offset);
  // File end with nothing reported yet gives a no-match beat, unless this byte hits
  assign produce    = hit || range_done || (src_data.last_byte && !decided);

  always_comb begin
    if (src_data.last_byte) begin
      byte_position_next = '0;
      decided_next       = 1'b0;
    end else begin
      byte_position_next = pos_full ? byte_position : pos_inc;
      decided_next       = decided || hit || range_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      decided       <= 1'b0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        byte_window[k] <= '0;
      end
    end else if (src_fire) begin
      byte_position <= byte_position_next;
      decided       <= decided_next;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        byte_window[k] <= src_data.last_byte ? 8'd0 : win_flat[8*k +: 8];
      end
    end
  end

  // Result register: load on an accepted byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (src_fire) begin
      res_valid <= produce;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire) begin
      res_data.matched      <= hit;
      res_data.match_offset <= hit ? start_cand : '0;
    end
  end

`ifndef SYNTHESIS
  a_res_after_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(src_fire))
    else $error("result appeared without an accepted byte");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.matched) |-> (res_data.match_offset == '0))
    else $error("no-match result carries an offset");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (src_fire && src_data.last_byte) |=> (byte_position == '0) && !decided)
    else $error("file end did not restart position");

  a_one_per_file: assert property (@(posedge clk) disable iff (rst)
    (src_fire && decided && !src_data.last_byte) |=> !res_valid)
    else $error("second result for one file");
`endif

endmodule
